[hdl/tiered_compaction_selector_top_defines.svh]
// Assertion helpers for the tiered compaction selector.
`ifndef TIERED_COMPACTION_SELECTOR_TOP_DEFINES_SVH
`define TIERED_COMPACTION_SELECTOR_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define TCS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define TCS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/tcs_pkg.sv]
`timescale 1ns / 1ps

package tcs_pkg;

	// store sizing
	localparam int MAX_GROUPS = 64;
	localparam int IDX_W      = $clog2(MAX_GROUPS);
	localparam int CNT_W      = $clog2(MAX_GROUPS + 1);

	// field widths
	localparam int TAG_W   = 16;
	localparam int BYTES_W = 48;
	localparam int MIN_W   = 6;
	localparam int FAC_W   = 5;
	localparam int PROD_W  = BYTES_W + FAC_W;

	// config port
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MIN_GROUPS  = 8'd0,
		CFG_SIZE_FACTOR = 8'd1
	} cfg_reg_t;

	localparam logic [MIN_W-1:0] MIN_RESET = MIN_W'(8);
	localparam logic [FAC_W-1:0] FAC_RESET = FAC_W'(8);

	// controller -> datapath
	typedef struct packed {
		logic load;       // take a load item
		logic rank_init;  // start the rank sort
		logic hold_i;     // latch entry i, restart scan
		logic scan;       // issue next compare read
		logic wr_sorted;  // place entry i at its rank
		logic walk_init;  // start the level walk
		logic walk;       // issue next walk read
		logic emit_init;  // set up the emit window
		logic emit_ld;    // load result register from sorted store
		logic nosel_ld;   // load the no-selection result
		logic out_done;   // result taken
		logic clear;      // drop the set
	} tcs_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic small_set;
		logic scan_done;
		logic i_last;
		logic walk_done;
		logic out_end;
	} tcs_status_t;

endpackage

[hdl/tcs_load_if.sv]
`timescale 1ns / 1ps

interface tcs_load_if;
	logic                        valid;
	logic                        ready;
	logic [tcs_pkg::TAG_W-1:0]   group_tag;
	logic [tcs_pkg::BYTES_W-1:0] group_bytes;
	logic                        last_group;

	modport source (output valid, group_tag, group_bytes, last_group, input ready);
	modport sink   (input valid, group_tag, group_bytes, last_group, output ready);
endinterface

[hdl/tcs_result_if.sv]
`timescale 1ns / 1ps

interface tcs_result_if;
	logic                      valid;
	logic                      ready;
	logic [tcs_pkg::TAG_W-1:0] chosen_tag;
	logic                      chosen_valid;
	logic                      overflowed;
	logic                      end_of_run;

	modport source (output valid, chosen_tag, chosen_valid, overflowed, end_of_run,
		input ready);
	modport sink   (input valid, chosen_tag, chosen_valid, overflowed, end_of_run,
		output ready);
endinterface

[hdl/tcs_cfg_if.sv]
`timescale 1ns / 1ps

interface tcs_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [tcs_pkg::CFG_IDX_W-1:0]  index;
	logic [tcs_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

[hdl/tcs_ctrl.sv]
`timescale 1ns / 1ps

module tcs_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load_valid,
	input  logic                 load_last,
	output logic                 load_ready,
	input  logic                 result_taken,
	input  tcs_pkg::tcs_status_t st,
	output tcs_pkg::tcs_cmd_t    cmd
);

	typedef enum logic [11:0] {
		ST_IDLE  = 12'b0000_0000_0001,
		ST_CHECK = 12'b0000_0000_0010,
		ST_RDI   = 12'b0000_0000_0100,
		ST_HOLD  = 12'b0000_0000_1000,
		ST_SCAN  = 12'b0000_0001_0000,
		ST_WR    = 12'b0000_0010_0000,
		ST_WINIT = 12'b0000_0100_0000,
		ST_WALK  = 12'b0000_1000_0000,
		ST_EINIT = 12'b0001_0000_0000,
		ST_ERD   = 12'b0010_0000_0000,
		ST_ELD   = 12'b0100_0000_0000,
		ST_OUT   = 12'b1000_0000_0000
	} state_t;

	state_t state_q, state_d;

	assign load_ready = (state_q == ST_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (load_valid) begin
					cmd.load = 1'b1;
					if (load_last) state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (st.small_set) begin
					cmd.nosel_ld = 1'b1;
					state_d      = ST_OUT;
				end else begin
					cmd.rank_init = 1'b1;
					state_d       = ST_RDI;
				end
			end
			ST_RDI: state_d = ST_HOLD;
			ST_HOLD: begin
				cmd.hold_i = 1'b1;
				state_d    = ST_SCAN;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (st.scan_done) state_d = ST_WR;
			end
			ST_WR: begin
				cmd.wr_sorted = 1'b1;
				state_d       = st.i_last ? ST_WINIT : ST_RDI;
			end
			ST_WINIT: begin
				cmd.walk_init = 1'b1;
				state_d       = ST_WALK;
			end
			ST_WALK: begin
				cmd.walk = 1'b1;
				if (st.walk_done) state_d = ST_EINIT;
			end
			ST_EINIT: begin
				cmd.emit_init = 1'b1;
				state_d       = ST_ERD;
			end
			ST_ERD: state_d = ST_ELD;
			ST_ELD: begin
				cmd.emit_ld = 1'b1;
				state_d     = ST_OUT;
			end
			ST_OUT: begin
				if (result_taken) begin
					cmd.out_done = 1'b1;
					if (st.out_end) begin
						cmd.clear = 1'b1;
						state_d   = ST_IDLE;
					end else begin
						state_d = ST_ERD;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

endmodule

[hdl/tcs_datapath.sv]
`timescale 1ns / 1ps

module tcs_datapath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  tcs_pkg::tcs_cmd_t               cmd,
	output tcs_pkg::tcs_status_t            st,
	input  logic                            cfg_we,
	input  logic [tcs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tcs_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic [tcs_pkg::TAG_W-1:0]       load_tag,
	input  logic [tcs_pkg::BYTES_W-1:0]     load_bytes,
	output logic                            out_valid,
	output logic [tcs_pkg::TAG_W-1:0]       out_tag,
	output logic                            out_chosen,
	output logic                            out_ovf,
	output logic                            out_end
);

	localparam int IDX_W   = tcs_pkg::IDX_W;
	localparam int CNT_W   = tcs_pkg::CNT_W;
	localparam int TAG_W   = tcs_pkg::TAG_W;
	localparam int BYTES_W = tcs_pkg::BYTES_W;
	localparam int MIN_W   = tcs_pkg::MIN_W;
	localparam int FAC_W   = tcs_pkg::FAC_W;
	localparam int PROD_W  = tcs_pkg::PROD_W;

	// registers
	logic [MIN_W-1:0] min_q;
	logic [FAC_W-1:0] fac_q;

	// load-order store and sorted store (smallest first, walk order)
	logic [BYTES_W-1:0] raw_size_mem [tcs_pkg::MAX_GROUPS];
	logic [TAG_W-1:0]   raw_tag_mem  [tcs_pkg::MAX_GROUPS];
	logic [BYTES_W-1:0] srt_size_mem [tcs_pkg::MAX_GROUPS];
	logic [TAG_W-1:0]   srt_tag_mem  [tcs_pkg::MAX_GROUPS];
	logic [BYTES_W-1:0] raw_rd_size_q, srt_rd_size_q;
	logic [TAG_W-1:0]   raw_rd_tag_q, srt_rd_tag_q;
	logic [IDX_W-1:0]   raw_addr, srt_addr;

	logic [CNT_W-1:0]   cnt_q;
	logic               ovf_q;

	// rank sort
	logic [CNT_W-1:0]   i_q, j_q;
	logic [IDX_W-1:0]   rank_q, j_s1;
	logic [BYTES_W-1:0] si_q;
	logic [TAG_W-1:0]   ti_q;
	logic               rv_s1;

	// level walk
	logic [CNT_W-1:0]   k_q, nums_q, nums_d;
	logic [IDX_W-1:0]   k_s1, lvl_start_q, sel_start_q;
	logic [PROD_W-1:0]  prod_q;
	logic               found_q, new_lvl;

	// emit
	logic [IDX_W-1:0]   pos_q;
	logic [CNT_W-1:0]   rem_q;
	logic [CNT_W-1:0]   min_ext;

	assign min_ext  = CNT_W'(min_q);
	assign raw_addr = cmd.scan ? j_q[IDX_W-1:0] : i_q[IDX_W-1:0];
	assign srt_addr = cmd.walk ? k_q[IDX_W-1:0] : pos_q;

	// status
	assign st.small_set = (cnt_q <= min_ext);
	assign st.scan_done = (j_q == cnt_q) && !rv_s1;
	assign st.i_last    = ((i_q + CNT_W'(1)) == cnt_q);
	assign st.walk_done = (k_q == cnt_q) && !rv_s1;
	assign st.out_end   = out_end;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= tcs_pkg::MIN_RESET;
			fac_q <= tcs_pkg::FAC_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				tcs_pkg::CFG_MIN_GROUPS:  min_q <= cfg_data[MIN_W-1:0];
				tcs_pkg::CFG_SIZE_FACTOR: fac_q <= cfg_data[FAC_W-1:0];
				default: ;
			endcase
		end
	end

	// raw store: written on load, read for the rank compares
	always_ff @(posedge clk) begin
		if (cmd.load && (cnt_q < CNT_W'(tcs_pkg::MAX_GROUPS))) begin
			raw_size_mem[cnt_q[IDX_W-1:0]] <= load_bytes;
			raw_tag_mem[cnt_q[IDX_W-1:0]]  <= load_tag;
		end
		raw_rd_size_q <= raw_size_mem[raw_addr];
		raw_rd_tag_q  <= raw_tag_mem[raw_addr];
	end

	// sorted store: written at rank, read for walk and emit
	always_ff @(posedge clk) begin
		if (cmd.wr_sorted) begin
			srt_size_mem[rank_q] <= si_q;
			srt_tag_mem[rank_q]  <= ti_q;
		end
		srt_rd_size_q <= srt_size_mem[srt_addr];
		srt_rd_tag_q  <= srt_tag_mem[srt_addr];
	end

	// fill count and overflow flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else if (cmd.clear) begin
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else if (cmd.load) begin
			if (cnt_q < CNT_W'(tcs_pkg::MAX_GROUPS)) cnt_q <= cnt_q + CNT_W'(1);
			else                                     ovf_q <= 1'b1;
		end
	end

	// rank sort: rank of i = smaller entries plus later-loaded equal entries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q   <= '0;
			j_q   <= '0;
			rv_s1 <= 1'b0;
		end else begin
			if (cmd.rank_init) i_q <= '0;
			if (cmd.wr_sorted) i_q <= i_q + CNT_W'(1);
			if (cmd.hold_i) begin
				j_q   <= '0;
				rv_s1 <= 1'b0;
			end else if (cmd.walk_init) begin
				rv_s1 <= 1'b0;
			end else if (cmd.scan) begin
				rv_s1 <= (j_q < cnt_q);
				if (j_q < cnt_q) j_q <= j_q + CNT_W'(1);
			end else if (cmd.walk) begin
				rv_s1 <= (k_q < cnt_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.hold_i) begin
			si_q   <= raw_rd_size_q;
			ti_q   <= raw_rd_tag_q;
			rank_q <= '0;
		end else if (cmd.scan && rv_s1) begin
			if ((raw_rd_size_q < si_q) ||
			    ((raw_rd_size_q == si_q) && (j_s1 > i_q[IDX_W-1:0])))
				rank_q <= rank_q + IDX_W'(1);
		end
		if (cmd.scan) j_s1 <= j_q[IDX_W-1:0];
	end

	// level walk over sorted store, smallest first
	assign new_lvl = (k_s1 == '0) || (PROD_W'(srt_rd_size_q) > prod_q);
	assign nums_d  = new_lvl ? CNT_W'(1) : (nums_q + CNT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q     <= '0;
			found_q <= 1'b0;
		end else if (cmd.walk_init) begin
			k_q     <= '0;
			found_q <= 1'b0;
		end else if (cmd.walk) begin
			if (k_q < cnt_q) k_q <= k_q + CNT_W'(1);
			if (rv_s1 && !found_q && (nums_d > min_ext)) found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.walk) begin
			k_s1 <= k_q[IDX_W-1:0];
			if (rv_s1) begin
				nums_q <= nums_d;
				if (new_lvl) begin
					prod_q      <= PROD_W'(srt_rd_size_q) * PROD_W'(fac_q);
					lvl_start_q <= k_s1;
				end
				if (!found_q && (nums_d > min_ext))
					sel_start_q <= new_lvl ? k_s1 : lvl_start_q;
			end
		end
	end

	// emit window
	always_ff @(posedge clk) begin
		if (cmd.emit_init) begin
			pos_q <= found_q ? sel_start_q : '0;
			rem_q <= found_q ? (min_ext + CNT_W'(1)) : min_ext;
		end else if (cmd.out_done) begin
			pos_q <= pos_q + IDX_W'(1);
			rem_q <= rem_q - CNT_W'(1);
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (cmd.emit_ld || cmd.nosel_ld) out_valid <= 1'b1;
		else if (cmd.out_done) out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.nosel_ld) begin
			out_tag    <= '0;
			out_chosen <= 1'b0;
			out_end    <= 1'b1;
			out_ovf    <= ovf_q;
		end else if (cmd.emit_ld) begin
			out_tag    <= srt_rd_tag_q;
			out_chosen <= 1'b1;
			out_end    <= (rem_q == CNT_W'(1));
			out_ovf    <= ovf_q;
		end
	end

endmodule

[hdl/tiered_compaction_selector_top.sv]
`timescale 1ns / 1ps

// Tiered compaction selector. Load items are stored as they arrive, back to
// back while idle; a load beyond the 64-group capacity is dropped and flagged.
// The item marked last_group starts selection: with n groups held, a rank sort
// reads the load store once per comparison through a single port, then a level
// walk passes over the sorted store, and each chosen group is delivered as a
// result held until result.ready takes it. While a set is being sorted or
// delivered, load.ready stays low. A set of no more than min_groups groups
// yields a single no-selection result. Configuration writes are always taken
// and belong in idle time between sets.
`include "tiered_compaction_selector_top_defines.svh"

module tiered_compaction_selector_top (
	input  logic         clk,
	input  logic         arst_n,
	tcs_load_if.sink     load,
	tcs_result_if.source result,
	tcs_cfg_if.sink      cfg
);

	tcs_pkg::tcs_cmd_t    cmd;
	tcs_pkg::tcs_status_t st;
	logic                 load_ready;

	assign cfg.ready  = 1'b1;
	assign load.ready = load_ready;

	tcs_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.load_valid   (load.valid),
		.load_last    (load.last_group),
		.load_ready   (load_ready),
		.result_taken (result.valid && result.ready),
		.st           (st),
		.cmd          (cmd)
	);

	tcs_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.st         (st),
		.cfg_we     (cfg.valid),
		.cfg_index  (cfg.index),
		.cfg_data   (cfg.data),
		.load_tag   (load.group_tag),
		.load_bytes (load.group_bytes),
		.out_valid  (result.valid),
		.out_tag    (result.chosen_tag),
		.out_chosen (result.chosen_valid),
		.out_ovf    (result.overflowed),
		.out_end    (result.end_of_run)
	);

	// no loads taken while a result is pending
	`TCS_ASSERT_NOW(a_no_load_during_result, result.valid, !load_ready, "load ready while result pending")
	// no-selection result is a lone, zero-tag end of run
	`TCS_ASSERT_NOW(a_nosel_shape, result.valid && !result.chosen_valid, result.end_of_run && (result.chosen_tag == '0), "malformed no-selection result")
	// taking the final result returns the block to loading
	`TCS_ASSERT_NEXT(a_back_to_load, result.valid && result.ready && result.end_of_run, load_ready && !result.valid, "not idle after end of run")

endmodule
